>>> rtl/tms_pkg.sv
// package for the tone melody sequencer: codes, types and divider constants
`timescale 1ns / 1ps

package tms_pkg;

  localparam int NOTE_DEPTH = 64;
  localparam int ADDR_W     = $clog2(NOTE_DEPTH);

  localparam longint unsigned PERIOD_BASE = 64'd1000;
  localparam longint unsigned DIVIDEND    = PERIOD_BASE * PERIOD_BASE;
  localparam int DVD_BITS = $clog2(DIVIDEND + 64'd1);
  // divider needs at least two quotient bits for its shift register
  localparam int DVD_W    = (DVD_BITS < 2) ? 2 : DVD_BITS;
  localparam int DCNT_W   = $clog2(DVD_W + 1);

  localparam int VAL_W    = 16;
  localparam int POS_W    = 7;
  localparam int LAST_W   = 6;
  localparam int THEME_W  = 3;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_PLAY   = 3'd2,
    OP_STOP   = 3'd3,
    OP_PAUSE  = 3'd4,
    OP_SINGLE = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [VAL_W-1:0] freq;
    logic [VAL_W-1:0] dur;
    logic [VAL_W-1:0] start;
  } note_entry_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

endpackage

>>> rtl/tms_note_ram.sv
// generic single-port-write, registered-read note table memory
`timescale 1ns / 1ps

module tms_note_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/tms_recip_div.sv
// iterative restoring divider: constant base squared over a 16-bit frequency
`timescale 1ns / 1ps

module tms_recip_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tms_pkg::div_req_t           req,
  output logic                        done,
  output logic [tms_pkg::DVD_W-1:0]   quotient
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [tms_pkg::DCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [tms_pkg::VAL_W-1:0]     rem_r, rem_nxt;
  logic [tms_pkg::DVD_W-1:0]     q_r, q_nxt;
  logic [tms_pkg::VAL_W-1:0]     div_r, div_nxt;
  logic [tms_pkg::VAL_W:0]       rem_shift;
  logic                          fits;

  // one quotient bit per cycle, dividend bits shifted out of q_r
  assign rem_shift = {rem_r, q_r[tms_pkg::DVD_W-1]};
  assign fits      = rem_shift >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = tms_pkg::DCNT_W'(tms_pkg::DVD_W);
      rem_nxt  = '0;
      q_nxt    = tms_pkg::DVD_W'(tms_pkg::DIVIDEND);
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? tms_pkg::VAL_W'(rem_shift - {1'b0, div_r})
                     : tms_pkg::VAL_W'(rem_shift);
      q_nxt   = {q_r[tms_pkg::DVD_W-2:0], fits};
      cnt_nxt = cnt_r - tms_pkg::DCNT_W'(1);
      if (cnt_r == tms_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> rtl/tone_melody_sequencer.sv
// top level of the tone melody sequencer
`timescale 1ns / 1ps

// Melody sequencer for a tone timer. Input words (in_valid / in_stall)
// carry one operation: tick, load note, play, stop, pause or single tone.
// Each accepted word yields exactly one result word (out_valid /
// out_stall) holding the reload value, timer flag, theme, remaining
// duration and note position after that operation.
// cfg_wr_en writes the sound enable bit (cfg_wr_data); write it only
// while no word is in flight.
// Words that do not compute a reload value go from accept through
// S_EVAL and S_DONE to out_valid; a sounding tick or a single tone of
// nonzero frequency also passes S_DIV, run by the 20-step iterative
// reload divider. One word is worked on at a time and the next is
// taken in the cycle after the result is written.
// The note table is a 64-entry memory with registered read.
// Reset clears all sequencer state, sets sound enable to 1 and leaves
// the note table contents undefined until loaded.
// While the receiver stalls, the finished result is held; the next word
// may be accepted and processed, but its result waits for the slot.

module tone_melody_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_operation,
  input  logic [5:0]                     in_note_index,
  input  logic [15:0]                    in_note_freq,
  input  logic [15:0]                    in_note_duration,
  input  logic [15:0]                    in_note_start,
  input  logic [6:0]                     in_note_count,
  input  logic [2:0]                     in_theme,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_tone_reload,
  output logic                           out_tone_enabled,
  output logic [2:0]                     out_playing_theme,
  output logic [15:0]                    out_remaining_duration,
  output logic [6:0]                     out_note_position
);

  tms_pkg::seq_state_t              state_r, state_nxt;

  tms_pkg::op_t                     op_r;
  logic [tms_pkg::VAL_W-1:0]        freq_r;
  logic [tms_pkg::VAL_W-1:0]        dur_r;
  logic [tms_pkg::POS_W-1:0]        count_r;
  logic [tms_pkg::THEME_W-1:0]      theme_in_r;

  logic [tms_pkg::POS_W-1:0]        pos_r, pos_nxt;
  logic [tms_pkg::LAST_W-1:0]       last_r, last_nxt;
  logic [tms_pkg::VAL_W-1:0]        tick_r, tick_nxt;
  logic [tms_pkg::VAL_W-1:0]        dleft_r, dleft_nxt;
  logic [tms_pkg::THEME_W-1:0]      theme_r, theme_nxt;
  logic [tms_pkg::VAL_W-1:0]        reload_r, reload_nxt;
  logic                             run_r, run_nxt;
  logic                             en_r;

  logic                             out_valid_r, out_valid_nxt;
  logic [tms_pkg::VAL_W-1:0]        out_reload_r;
  logic                             out_run_r;
  logic [tms_pkg::THEME_W-1:0]      out_theme_r;
  logic [tms_pkg::VAL_W-1:0]        out_dleft_r;
  logic [tms_pkg::POS_W-1:0]        out_pos_r;

  logic                             in_accept;
  logic                             slot_free;
  tms_pkg::note_entry_t             wr_entry;
  tms_pkg::note_entry_t             rd_entry;
  logic [$bits(tms_pkg::note_entry_t)-1:0] rd_bits;

  tms_pkg::div_req_t                div_req;
  logic                             div_done;
  logic [tms_pkg::DVD_W-1:0]        div_quot;

  logic                             tick_active;
  logic                             note_due;
  logic                             in_melody;
  logic                             div_go;
  logic [tms_pkg::VAL_W-1:0]        dleft_dec;
  logic [tms_pkg::VAL_W-1:0]        reload_dec;
  logic [tms_pkg::VAL_W-1:0]        tick_inc;
  logic [tms_pkg::POS_W-1:0]        pos_inc;
  logic [tms_pkg::LAST_W-1:0]       count_last;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != tms_pkg::S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  assign wr_entry.freq  = in_note_freq;
  assign wr_entry.dur   = in_note_duration;
  assign wr_entry.start = in_note_start;

  // entry for the current position is read at accept, ready in S_EVAL
  tms_note_ram #(
    .DEPTH (tms_pkg::NOTE_DEPTH),
    .WIDTH ($bits(tms_pkg::note_entry_t))
  ) u_note_ram (
    .clk     (clk),
    .wr_en   (in_accept && (tms_pkg::op_t'(in_operation) == tms_pkg::OP_LOAD)),
    .wr_addr (tms_pkg::ADDR_W'(in_note_index)),
    .wr_data (wr_entry),
    .rd_en   (in_accept),
    .rd_addr (tms_pkg::ADDR_W'(pos_r)),
    .rd_data (rd_bits)
  );

  assign rd_entry = tms_pkg::note_entry_t'(rd_bits);

  tms_recip_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quot)
  );

  // tick arithmetic
  assign tick_active = (theme_r != '0) && en_r;
  assign dleft_dec   = (dleft_r != '0) ? dleft_r - tms_pkg::VAL_W'(1) : dleft_r;
  assign reload_dec  = (dleft_r == tms_pkg::VAL_W'(1)) ? '0 : reload_r;
  assign tick_inc    = (tick_r != '1) ? tick_r + tms_pkg::VAL_W'(1) : tick_r;
  assign note_due    = tick_inc >= rd_entry.start;
  assign in_melody   = pos_r < {1'b0, last_r};
  assign pos_inc     = pos_r + tms_pkg::POS_W'(1);
  assign count_last  = tms_pkg::LAST_W'(count_r - tms_pkg::POS_W'(1));

  always_comb begin
    div_go = 1'b0;
    if (state_r == tms_pkg::S_EVAL) begin
      case (op_r)
        tms_pkg::OP_TICK: begin
          div_go = tick_active && note_due && in_melody && (rd_entry.freq != '0);
        end
        tms_pkg::OP_SINGLE: begin
          div_go = (freq_r != '0);
        end
        default: begin
          div_go = 1'b0;
        end
      endcase
    end
  end

  assign div_req.start   = div_go;
  assign div_req.divisor = (op_r == tms_pkg::OP_SINGLE) ? freq_r : rd_entry.freq;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tms_pkg::S_IDLE: begin
        if (in_accept) state_nxt = tms_pkg::S_EVAL;
      end
      tms_pkg::S_EVAL: begin
        state_nxt = div_go ? tms_pkg::S_DIV : tms_pkg::S_DONE;
      end
      tms_pkg::S_DIV: begin
        if (div_done) state_nxt = tms_pkg::S_DONE;
      end
      tms_pkg::S_DONE: begin
        if (slot_free) state_nxt = tms_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tms_pkg::S_IDLE;
      end
    endcase
  end

  // sequencer state updates
  always_comb begin
    pos_nxt    = pos_r;
    last_nxt   = last_r;
    tick_nxt   = tick_r;
    dleft_nxt  = dleft_r;
    theme_nxt  = theme_r;
    reload_nxt = reload_r;
    run_nxt    = run_r;
    case (state_r)
      tms_pkg::S_EVAL: begin
        case (op_r)
          tms_pkg::OP_TICK: begin
            if (tick_active) begin
              dleft_nxt  = dleft_dec;
              reload_nxt = reload_dec;
              tick_nxt   = tick_inc;
              if (note_due) begin
                if (in_melody) begin
                  // zero frequency holds the position on this entry
                  if (rd_entry.freq != '0) begin
                    dleft_nxt = rd_entry.dur;
                    run_nxt   = 1'b1;
                    pos_nxt   = pos_inc;
                  end
                end else begin
                  // end of melody
                  theme_nxt = '0;
                  tick_nxt  = '0;
                  dleft_nxt = '0;
                  pos_nxt   = '0;
                  last_nxt  = '1;
                  run_nxt   = 1'b0;
                end
              end
            end
          end
          tms_pkg::OP_PLAY: begin
            theme_nxt = theme_in_r;
            tick_nxt  = '0;
            dleft_nxt = '0;
            pos_nxt   = '0;
            last_nxt  = (theme_in_r != '0) ? count_last : '1;
            run_nxt   = 1'b1;
          end
          tms_pkg::OP_STOP: begin
            theme_nxt = '0;
            tick_nxt  = '0;
            dleft_nxt = '0;
            pos_nxt   = '0;
            last_nxt  = '1;
          end
          tms_pkg::OP_PAUSE: begin
            theme_nxt = '0;
          end
          tms_pkg::OP_SINGLE: begin
            if (freq_r != '0) dleft_nxt = dur_r;
          end
          default: begin
            pos_nxt = pos_r;
          end
        endcase
      end
      tms_pkg::S_DIV: begin
        if (div_done) reload_nxt = tms_pkg::VAL_W'(div_quot);
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if ((state_r == tms_pkg::S_DONE) && slot_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tms_pkg::S_IDLE;
      pos_r       <= '0;
      last_r      <= '0;
      tick_r      <= '0;
      dleft_r     <= '0;
      theme_r     <= '0;
      reload_r    <= '0;
      run_r       <= 1'b0;
      en_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      last_r      <= last_nxt;
      tick_r      <= tick_nxt;
      dleft_r     <= dleft_nxt;
      theme_r     <= theme_nxt;
      reload_r    <= reload_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) en_r <= cfg_wr_data;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r       <= tms_pkg::op_t'(in_operation);
      freq_r     <= in_note_freq;
      dur_r      <= in_note_duration;
      count_r    <= in_note_count;
      theme_in_r <= in_theme;
    end
    if ((state_r == tms_pkg::S_DONE) && slot_free) begin
      out_reload_r <= reload_r;
      out_run_r    <= run_r;
      out_theme_r  <= theme_r;
      out_dleft_r  <= dleft_r;
      out_pos_r    <= pos_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_tone_reload        = out_reload_r;
  assign out_tone_enabled       = out_run_r;
  assign out_playing_theme      = out_theme_r;
  assign out_remaining_duration = out_dleft_r;
  assign out_note_position      = out_pos_r;

endmodule

>>> tb/sv/tb_tone_melody_sequencer.sv
// self-checking testbench for the tone melody sequencer
`timescale 1ns / 1ps

module tb_tone_melody_sequencer;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int RANDOM_WORDS  = 1650;
  localparam int CLOSING_WORDS = 52;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int TAIL_CYCLES   = 40;

  typedef struct {
    logic [2:0]  op;
    logic [5:0]  idx;
    logic [15:0] freq;
    logic [15:0] dur;
    logic [15:0] start;
    logic [6:0]  count;
    logic [2:0]  theme;
  } note_word_t;

  typedef struct {
    logic [15:0] reload;
    logic        enabled;
    logic [2:0]  theme;
    logic [15:0] remaining;
    logic [6:0]  position;
  } seq_state_word_t;

  // mirror of the sequencer plus the states it is still due to report
  class melody_scoreboard;
    logic [15:0] freq_tbl[tms_pkg::NOTE_DEPTH];
    logic [15:0] dur_tbl[tms_pkg::NOTE_DEPTH];
    logic [15:0] start_tbl[tms_pkg::NOTE_DEPTH];
    logic [6:0]  pos;
    logic [5:0]  last_pos;
    logic [15:0] ticks;
    logic [15:0] dur_left;
    logic [2:0]  theme;
    logic [15:0] reload;
    logic        running;
    logic        sound_on;
    seq_state_word_t pending_states[$];
    int errors;

    function new();
      pos      = '0;
      last_pos = '0;
      ticks    = '0;
      dur_left = '0;
      theme    = '0;
      reload   = '0;
      running  = 1'b0;
      sound_on = 1'b1;
      errors   = 0;
    endfunction

    function void set_sound_enable(logic v);
      sound_on = v;
    endfunction

    function logic [15:0] reload_of(logic [15:0] f);
      longint unsigned q;
      q = (tms_pkg::PERIOD_BASE * tms_pkg::PERIOD_BASE) / longint'(f);
      return q[15:0];
    endfunction

    function void rewind(logic [6:0] cnt);
      ticks    = '0;
      dur_left = '0;
      pos      = '0;
      last_pos = cnt[5:0] - 6'd1;
    endfunction

    function void advance_tick();
      logic [5:0] idx;
      if (theme == 0 || !sound_on) return;
      if (dur_left != 0) begin
        dur_left--;
        if (dur_left == 0) reload = '0;
      end
      if (ticks != 16'hFFFF) ticks++;
      idx = pos[5:0];
      if (ticks >= start_tbl[idx]) begin
        if (pos < {1'b0, last_pos}) begin
          // zero frequency parks the sequence on this entry
          if (freq_tbl[idx] == 0) return;
          reload   = reload_of(freq_tbl[idx]);
          dur_left = dur_tbl[idx];
          running  = 1'b1;
        end
        pos = pos + 7'd1;
        if (pos > {1'b0, last_pos}) begin
          theme   = '0;
          rewind('0);
          running = 1'b0;
        end
      end
    endfunction

    function void apply_word(note_word_t w);
      seq_state_word_t s;
      case (w.op)
        tms_pkg::OP_TICK: advance_tick();
        tms_pkg::OP_LOAD: begin
          freq_tbl[w.idx]  = w.freq;
          dur_tbl[w.idx]   = w.dur;
          start_tbl[w.idx] = w.start;
        end
        tms_pkg::OP_PLAY: begin
          theme = w.theme;
          rewind((w.theme != 0) ? w.count : 7'd0);
          running = 1'b1;
        end
        tms_pkg::OP_STOP: begin
          theme = '0;
          rewind('0);
        end
        tms_pkg::OP_PAUSE: theme = '0;
        tms_pkg::OP_SINGLE: begin
          if (w.freq != 0) begin
            reload   = reload_of(w.freq);
            dur_left = w.dur;
          end
        end
        default: ;
      endcase
      s.reload    = reload;
      s.enabled   = running;
      s.theme     = theme;
      s.remaining = dur_left;
      s.position  = pos;
      pending_states.push_back(s);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void compare_state(logic [15:0] reload_o, logic enabled_o, logic [2:0] theme_o,
                                logic [15:0] remaining_o, logic [6:0] position_o);
      seq_state_word_t s;
      if (pending_states.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      s = pending_states.pop_front();
      check_field("tone_reload", s.reload, reload_o);
      check_field("tone_enabled", 16'(s.enabled), 16'(enabled_o));
      check_field("playing_theme", 16'(s.theme), 16'(theme_o));
      check_field("remaining_duration", s.remaining, remaining_o);
      check_field("note_position", 16'(s.position), 16'(position_o));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_operation = '0;
  logic [5:0]  in_note_index = '0;
  logic [15:0] in_note_freq = '0;
  logic [15:0] in_note_duration = '0;
  logic [15:0] in_note_start = '0;
  logic [6:0]  in_note_count = '0;
  logic [2:0]  in_theme = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_tone_reload;
  logic        out_tone_enabled;
  logic [2:0]  out_playing_theme;
  logic [15:0] out_remaining_duration;
  logic [6:0]  out_note_position;

  melody_scoreboard sb = new();

  int  words_sent = 0;
  int  burst_left = 0;
  bit  tx_steady = 1'b0;
  bit  rx_quiet = 1'b0;
  int  rx_mode = 0;
  int  stall_run = 0;
  int  rx_phase = 0;
  int  cycle_count = 0;

  tone_melody_sequencer u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_operation           (in_operation),
    .in_note_index          (in_note_index),
    .in_note_freq           (in_note_freq),
    .in_note_duration       (in_note_duration),
    .in_note_start          (in_note_start),
    .in_note_count          (in_note_count),
    .in_theme               (in_theme),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_tone_reload        (out_tone_reload),
    .out_tone_enabled       (out_tone_enabled),
    .out_playing_theme      (out_playing_theme),
    .out_remaining_duration (out_remaining_duration),
    .out_note_position      (out_note_position)
  );

  always #5 clk = ~clk;

  // receiver: check each accepted result, then pick the next stall level
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.compare_state(out_tone_reload, out_tone_enabled, out_playing_theme,
                       out_remaining_duration, out_note_position);
    end
    rx_phase <= rx_phase + 1;
    if (rx_phase % 256 == 255) rx_mode <= $urandom_range(0, 2);
    if (!rst_n || rx_quiet) begin
      out_stall <= 1'b0;
    end else if (stall_run != 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else begin
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            out_stall <= 1'b1;
            stall_run <= $urandom_range(1, 30);
          end else begin
            out_stall <= 1'($urandom_range(0, 1));
          end
        end
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic note_word_t noise_word();
    note_word_t w;
    w.op    = 3'($urandom_range(0, 7));
    w.idx   = 6'($urandom_range(0, 63));
    w.freq  = 16'($urandom_range(0, 65535));
    w.dur   = 16'($urandom_range(0, 65535));
    w.start = 16'($urandom_range(0, 65535));
    w.count = 7'($urandom_range(0, 127));
    w.theme = 3'($urandom_range(0, 7));
    return w;
  endfunction

  function automatic note_word_t bare_word(logic [2:0] op);
    note_word_t w;
    w    = noise_word();
    w.op = op;
    return w;
  endfunction

  function automatic note_word_t load_word(logic [5:0] idx, logic [15:0] freq,
                                           logic [15:0] dur, logic [15:0] start);
    note_word_t w;
    w       = bare_word(tms_pkg::OP_LOAD);
    w.idx   = idx;
    w.freq  = freq;
    w.dur   = dur;
    w.start = start;
    return w;
  endfunction

  function automatic note_word_t play_word(logic [2:0] theme, logic [6:0] count);
    note_word_t w;
    w       = bare_word(tms_pkg::OP_PLAY);
    w.theme = theme;
    w.count = count;
    return w;
  endfunction

  function automatic note_word_t tone_word(logic [15:0] freq, logic [15:0] dur);
    note_word_t w;
    w      = bare_word(tms_pkg::OP_SINGLE);
    w.freq = freq;
    w.dur  = dur;
    return w;
  endfunction

  function automatic logic [15:0] pick_freq();
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 15));
      2: return 16'($urandom_range(1, 65535));
      default: return 16'($urandom_range(100, 4000));
    endcase
  endfunction

  function automatic logic [15:0] pick_dur();
    if ($urandom_range(0, 9) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 6));
  endfunction

  // hold the word until taken, then maybe drop valid for a gap
  task automatic push_word(input note_word_t w);
    int gap;
    in_valid         <= 1'b1;
    in_operation     <= w.op;
    in_note_index    <= w.idx;
    in_note_freq     <= w.freq;
    in_note_duration <= w.dur;
    in_note_start    <= w.start;
    in_note_count    <= w.count;
    in_theme         <= w.theme;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.apply_word(w);
    words_sent++;
    if (!tx_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sound_enable(input logic v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_sound_enable(v);
  endtask

  function automatic note_word_t upset_word();
    case ($urandom_range(0, 4))
      0: return tone_word(pick_freq(), pick_dur());
      1: return bare_word(tms_pkg::OP_PAUSE);
      2: return bare_word(tms_pkg::OP_STOP);
      3: return play_word(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
      default: return noise_word();
    endcase
  endfunction

  // load a short melody, play it and tick it through to its end
  task automatic run_melody();
    int n;
    int ticks;
    logic [15:0] at;
    logic [6:0] cnt;
    n  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(2, 8);
    at = '0;
    for (int i = 0; i < n; i++) begin
      push_word(load_word(6'(i), pick_freq(), pick_dur(), at));
      at += 16'($urandom_range(0, 3));
    end
    cnt = 7'(n);
    if ($urandom_range(0, 5) == 0) cnt = 7'($urandom_range(1, n));
    if (n == 64 && $urandom_range(0, 1) == 0) cnt = 7'd0;
    push_word(play_word(3'($urandom_range(1, 7)), cnt));
    ticks = int'(at) + n + $urandom_range(0, 6);
    repeat (ticks) begin
      if ($urandom_range(0, 24) == 0) push_word(upset_word());
      else push_word(bare_word(tms_pkg::OP_TICK));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_sound_enable(1'b1);

    // fill the whole table so that no later tick reads an unloaded entry
    for (int i = 0; i < tms_pkg::NOTE_DEPTH; i++) begin
      push_word(load_word(6'(i), pick_freq(), pick_dur(),
                          ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                      : 16'($urandom_range(0, 300))));
    end

    // directed corners
    push_word(bare_word(tms_pkg::OP_TICK));
    push_word(tone_word(16'd1, 16'd3));
    push_word(tone_word(16'hFFFF, 16'hFFFF));
    push_word(tone_word(16'd0, 16'd5));
    push_word(bare_word(OP_SPARE_LO));
    push_word(bare_word(OP_SPARE_HI));
    push_word(play_word(3'd0, 7'd5));
    push_word(load_word(6'd0, 16'd0, 16'd2, 16'd0));
    push_word(load_word(6'd1, 16'd440, 16'd1, 16'd1));
    push_word(load_word(6'd2, 16'd0, 16'd0, 16'd2));
    push_word(play_word(3'd7, 7'd3));
    push_word(bare_word(tms_pkg::OP_TICK));
    push_word(bare_word(tms_pkg::OP_TICK));
    push_word(bare_word(tms_pkg::OP_PAUSE));
    push_word(bare_word(tms_pkg::OP_TICK));
    push_word(load_word(6'd0, 16'd1000, 16'd1, 16'd0));
    push_word(play_word(3'd1, 7'd3));
    repeat (3) push_word(bare_word(tms_pkg::OP_TICK));
    push_word(play_word(3'd3, 7'd0));
    push_word(bare_word(tms_pkg::OP_STOP));
    push_word(play_word(3'd2, 7'd1));
    push_word(bare_word(tms_pkg::OP_TICK));

    // sound off: ticks must leave the sequencer alone
    write_sound_enable(1'b0);
    run_melody();
    write_sound_enable(1'b1);

    while (words_sent < RANDOM_WORDS - CLOSING_WORDS) begin
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 8)) push_word(noise_word());
      else run_melody();
      if ($urandom_range(0, 29) == 0) settle();
    end

    // short melody with both sides at full rate
    settle();
    tx_steady = 1'b1;
    rx_quiet  = 1'b1;
    push_word(load_word(6'd0, 16'd500, 16'd3, 16'd1));
    push_word(load_word(6'd1, 16'd2000, 16'd2, 16'd2));
    push_word(load_word(6'd2, 16'd0, 16'd0, 16'd4));
    push_word(play_word(3'd5, 7'd3));
    repeat (8) push_word(bare_word(tms_pkg::OP_TICK));
    settle();
    tx_steady = 1'b0;
    rx_quiet  = 1'b0;

    write_sound_enable(1'b0);
    repeat (20) push_word(noise_word());
    write_sound_enable(1'b1);
    repeat (20) push_word(noise_word());

    in_valid <= 1'b0;
    while (sb.pending_states.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/tms_pkg.sv
rtl/tms_note_ram.sv
rtl/tms_recip_div.sv
rtl/tone_melody_sequencer.sv
tb/sv/tb_tone_melody_sequencer.sv
